// File: hw/rtl/skin_pixel_classifier_assert.svh
// Assertion macros for the skin pixel classifier.
`ifndef SKIN_PIXEL_CLASSIFIER_ASSERT_SVH
`define SKIN_PIXEL_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define SPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define SPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/spc_pkg.sv
//------------------------------------------------------------------------------
// spc_pkg
// Shared types, register codes and fixed-point constants for the skin pixel
// classifier.
//------------------------------------------------------------------------------
package spc_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int PIX_W         = 8;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 8;
   localparam int NUM_STAGES    = 4;
   localparam int HUE_T_W       = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_RED_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_MIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HUE_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HUE_HIGH  = 3'd4;

   localparam logic [PIX_W-1:0] RST_RED_MIN   = 8'd90;
   localparam logic [PIX_W-1:0] RST_GREEN_MIN = 8'd35;
   localparam logic [PIX_W-1:0] RST_BLUE_MIN  = 8'd15;
   localparam logic [PIX_W-1:0] RST_HUE_LOW   = 8'd25;
   localparam logic [PIX_W-1:0] RST_HUE_HIGH  = 8'd225;

   localparam logic [PIX_W-1:0] DIFF_MIN = 8'd15;
   localparam logic [PIX_W-1:0] FLASH_R  = 8'd220;
   localparam logic [PIX_W-1:0] FLASH_G  = 8'd210;
   localparam logic [PIX_W-1:0] FLASH_B  = 8'd170;

   // max component sector
   localparam logic [1:0] MAX_RED   = 2'd0;
   localparam logic [1:0] MAX_GREEN = 2'd1;
   localparam logic [1:0] MAX_BLUE  = 2'd2;

   // coefficients in millionths
   localparam longint M_CR_R = 500000;
   localparam longint M_CR_G = 418688;
   localparam longint M_CR_B = 81312;
   localparam longint M_CB_R = 168736;
   localparam longint M_CB_G = 331264;
   localparam longint M_CB_B = 500000;

   localparam longint M_B3_SLOPE = 1586200;
   localparam longint M_B3_OFF   = 20000000;
   localparam longint M_B4_SLOPE = 344800;
   localparam longint M_B4_OFF   = 76206900;
   localparam longint M_B5_SLOPE = 4565200;
   localparam longint M_B5_OFF   = 234565200;
   localparam longint M_B6_SLOPE = 1150000;
   localparam longint M_B6_OFF   = 301750000;
   localparam longint M_B7_SLOPE = 2285700;
   localparam longint M_B7_OFF   = 432850000;

   // millionths to FRAC_BITS fraction bits, rounded half up
   function automatic longint qc_round(input longint m, input int frac);
      return (m * (longint'(1) << frac) + 64'sd500000) / 64'sd1000000;
   endfunction

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             last;
   } pix_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_min;
      logic [PIX_W-1:0] green_min;
      logic [PIX_W-1:0] blue_min;
      logic [PIX_W-1:0] hue_low;
      logic [PIX_W-1:0] hue_high;
   } csr_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctl_type;

endpackage

// File: hw/rtl/spc_pipe_ctrl.sv
//------------------------------------------------------------------------------
// spc_pipe_ctrl
// Valid bits and per-stage load enables; bubbles collapse under a stall.
//------------------------------------------------------------------------------
module spc_pipe_ctrl
   import spc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic         out_ready,
   output logic         in_ready,
   output pipe_ctl_type ctl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] rdy;

   always_comb begin
      rdy[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
      valid_in[0] = rdy[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = rdy[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = rdy[0];
   assign ctl.load  = rdy;
   assign ctl.valid = valid_ff;

endmodule

// File: hw/rtl/spc_front.sv
//------------------------------------------------------------------------------
// spc_front
// Stage 1: RGB rule, max/min sector, Cr/Cb weighted sums.
//------------------------------------------------------------------------------
module spc_front
   import spc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                        clock,
   input  logic                        load,
   input  pix_type                     pix_i,
   input  csr_type                     csr,
   output pix_type                     pix_o,
   output logic signed [FRAC_BITS+10:0] cr_sum_o,
   output logic signed [FRAC_BITS+10:0] cb_sum_o,
   output logic                        rgb_ok_o,
   output logic [1:0]                  max_sel_o,
   output logic [PIX_W-1:0]            delta_o
);

   localparam int SW = FRAC_BITS + 11;
   localparam logic signed [SW-1:0] BIAS =
      SW'((longint'(128) << FRAC_BITS) + (longint'(1) << (FRAC_BITS - 1)));
   localparam logic signed [SW-1:0] K_CR_R = SW'(qc_round(M_CR_R, FRAC_BITS));
   localparam logic signed [SW-1:0] K_CR_G = SW'(qc_round(M_CR_G, FRAC_BITS));
   localparam logic signed [SW-1:0] K_CR_B = SW'(qc_round(M_CR_B, FRAC_BITS));
   localparam logic signed [SW-1:0] K_CB_R = SW'(qc_round(M_CB_R, FRAC_BITS));
   localparam logic signed [SW-1:0] K_CB_G = SW'(qc_round(M_CB_G, FRAC_BITS));
   localparam logic signed [SW-1:0] K_CB_B = SW'(qc_round(M_CB_B, FRAC_BITS));

   logic signed [SW-1:0] r_s, g_s, b_s;
   logic signed [SW-1:0] cr_sum_in, cb_sum_in;
   logic [PIX_W-1:0]     mx, mn, drg, delta_in;
   logic [1:0]           max_sel_in;
   logic                 day, flash, rgb_ok_in;

   pix_type              pix_ff;
   logic signed [SW-1:0] cr_sum_ff, cb_sum_ff;
   logic                 rgb_ok_ff;
   logic [1:0]           max_sel_ff;
   logic [PIX_W-1:0]     delta_ff;

   always_comb begin
      r_s = signed'(SW'(pix_i.red));
      g_s = signed'(SW'(pix_i.green));
      b_s = signed'(SW'(pix_i.blue));
      cr_sum_in = BIAS + K_CR_R * r_s - K_CR_G * g_s - K_CR_B * b_s;
      cb_sum_in = BIAS - K_CB_R * r_s - K_CB_G * g_s + K_CB_B * b_s;

      if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
         max_sel_in = MAX_RED;
         mx         = pix_i.red;
      end else if (pix_i.green >= pix_i.blue) begin
         max_sel_in = MAX_GREEN;
         mx         = pix_i.green;
      end else begin
         max_sel_in = MAX_BLUE;
         mx         = pix_i.blue;
      end

      if (pix_i.red <= pix_i.green && pix_i.red <= pix_i.blue) begin
         mn = pix_i.red;
      end else if (pix_i.green <= pix_i.blue) begin
         mn = pix_i.green;
      end else begin
         mn = pix_i.blue;
      end

      delta_in = mx - mn;
      drg = (pix_i.red > pix_i.green) ? pix_i.red - pix_i.green
                                      : pix_i.green - pix_i.red;

      day = pix_i.red > csr.red_min && pix_i.green > csr.green_min &&
            pix_i.blue > csr.blue_min && delta_in > DIFF_MIN && drg > DIFF_MIN &&
            pix_i.red > pix_i.green && pix_i.red > pix_i.blue;
      flash = pix_i.red > FLASH_R && pix_i.green > FLASH_G && pix_i.blue > FLASH_B &&
              drg <= DIFF_MIN && pix_i.red > pix_i.blue && pix_i.green > pix_i.blue;
      rgb_ok_in = day || flash;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff     <= pix_i;
         cr_sum_ff  <= cr_sum_in;
         cb_sum_ff  <= cb_sum_in;
         rgb_ok_ff  <= rgb_ok_in;
         max_sel_ff <= max_sel_in;
         delta_ff   <= delta_in;
      end
   end

   assign pix_o     = pix_ff;
   assign cr_sum_o  = cr_sum_ff;
   assign cb_sum_o  = cb_sum_ff;
   assign rgb_ok_o  = rgb_ok_ff;
   assign max_sel_o = max_sel_ff;
   assign delta_o   = delta_ff;

endmodule

// File: hw/rtl/spc_convert.sv
//------------------------------------------------------------------------------
// spc_convert
// Stage 2: Cr/Cb rounding and saturation, hue numerator in degrees.
//------------------------------------------------------------------------------
module spc_convert
   import spc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                         clock,
   input  logic                         load,
   input  pix_type                      pix_i,
   input  logic signed [FRAC_BITS+10:0] cr_sum_i,
   input  logic signed [FRAC_BITS+10:0] cb_sum_i,
   input  logic                         rgb_ok_i,
   input  logic [1:0]                   max_sel_i,
   input  logic [PIX_W-1:0]             delta_i,
   output pix_type                      pix_o,
   output logic [PIX_W-1:0]             cr_o,
   output logic [PIX_W-1:0]             cb_o,
   output logic                         rgb_ok_o,
   output logic [HUE_T_W-1:0]           hue_t_o,
   output logic [PIX_W-1:0]             delta_o,
   output logic                         grey_o
);

   localparam int SW = FRAC_BITS + 11;
   localparam int TW = HUE_T_W + 1;
   localparam logic signed [TW-1:0] C60  = TW'(60);
   localparam logic signed [TW-1:0] C120 = TW'(120);
   localparam logic signed [TW-1:0] C240 = TW'(240);
   localparam logic signed [TW-1:0] C360 = TW'(360);

   function automatic logic [PIX_W-1:0] sat8(input logic signed [SW-1:0] sum);
      logic signed [SW-1:0] shifted;
      shifted = sum >>> FRAC_BITS;
      if (sum < 0) begin
         return '0;
      end else if (shifted > SW'(255)) begin
         return '1;
      end else begin
         return shifted[PIX_W-1:0];
      end
   endfunction

   logic signed [TW-1:0] r_e, g_e, b_e, d_e, t_raw, t_wrap;

   pix_type              pix_ff;
   logic [PIX_W-1:0]     cr_ff, cb_ff, delta_ff;
   logic                 rgb_ok_ff, grey_ff;
   logic [HUE_T_W-1:0]   hue_t_ff;

   always_comb begin
      r_e = signed'(TW'(pix_i.red));
      g_e = signed'(TW'(pix_i.green));
      b_e = signed'(TW'(pix_i.blue));
      d_e = signed'(TW'(delta_i));
      case (max_sel_i)
         MAX_RED: begin
            t_raw = C60 * (g_e - b_e);
         end
         MAX_GREEN: begin
            t_raw = C120 * d_e + C60 * (b_e - r_e);
         end
         default: begin
            t_raw = C240 * d_e + C60 * (r_e - g_e);
         end
      endcase
      t_wrap = (t_raw < 0) ? t_raw + C360 * d_e : t_raw;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff    <= pix_i;
         cr_ff     <= sat8(cr_sum_i);
         cb_ff     <= sat8(cb_sum_i);
         rgb_ok_ff <= rgb_ok_i;
         hue_t_ff  <= t_wrap[HUE_T_W-1:0];
         delta_ff  <= delta_i;
         grey_ff   <= (delta_i == '0);
      end
   end

   assign pix_o    = pix_ff;
   assign cr_o     = cr_ff;
   assign cb_o     = cb_ff;
   assign rgb_ok_o = rgb_ok_ff;
   assign hue_t_o  = hue_t_ff;
   assign delta_o  = delta_ff;
   assign grey_o   = grey_ff;

endmodule

// File: hw/rtl/spc_decide.sv
//------------------------------------------------------------------------------
// spc_decide
// Stage 3: five Cr/Cb line bounds, hue window, final skin decision.
//------------------------------------------------------------------------------
module spc_decide
   import spc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic               clock,
   input  logic               load,
   input  pix_type            pix_i,
   input  logic [PIX_W-1:0]   cr_i,
   input  logic [PIX_W-1:0]   cb_i,
   input  logic               rgb_ok_i,
   input  logic [HUE_T_W-1:0] hue_t_i,
   input  logic [PIX_W-1:0]   delta_i,
   input  logic               grey_i,
   input  csr_type            csr,
   output pix_type            pix_o,
   output logic               skin_o
);

   localparam int CW = FRAC_BITS + 13;
   localparam int HW = 22;
   localparam logic signed [CW-1:0] K3 = CW'(qc_round(M_B3_SLOPE, FRAC_BITS));
   localparam logic signed [CW-1:0] O3 = CW'(qc_round(M_B3_OFF, FRAC_BITS));
   localparam logic signed [CW-1:0] K4 = CW'(qc_round(M_B4_SLOPE, FRAC_BITS));
   localparam logic signed [CW-1:0] O4 = CW'(qc_round(M_B4_OFF, FRAC_BITS));
   localparam logic signed [CW-1:0] K5 = CW'(qc_round(M_B5_SLOPE, FRAC_BITS));
   localparam logic signed [CW-1:0] O5 = CW'(qc_round(M_B5_OFF, FRAC_BITS));
   localparam logic signed [CW-1:0] K6 = CW'(qc_round(M_B6_SLOPE, FRAC_BITS));
   localparam logic signed [CW-1:0] O6 = CW'(qc_round(M_B6_OFF, FRAC_BITS));
   localparam logic signed [CW-1:0] K7 = CW'(qc_round(M_B7_SLOPE, FRAC_BITS));
   localparam logic signed [CW-1:0] O7 = CW'(qc_round(M_B7_OFF, FRAC_BITS));

   logic signed [CW-1:0] lhs, cb_s;
   logic                 e3, e4, e5, e6, e7, crcb_ok, hue_ok, skin_in;
   logic [HW-1:0]        t17, lo24, hi24;

   pix_type              pix_ff;
   logic                 skin_ff;

   always_comb begin
      lhs  = signed'(CW'(cr_i)) <<< FRAC_BITS;
      cb_s = signed'(CW'(cb_i));
      e3 = lhs <= K3 * cb_s + O3;
      e4 = lhs >= K4 * cb_s + O4;
      e5 = lhs >= O5 - K5 * cb_s;
      e6 = lhs <= O6 - K6 * cb_s;
      e7 = lhs <= O7 - K7 * cb_s;
      crcb_ok = e3 && e4 && e5 && e6 && e7;

      t17  = HW'(hue_t_i) * HW'(17);
      lo24 = HW'(csr.hue_low) * HW'(delta_i) * HW'(24);
      hi24 = HW'(csr.hue_high) * HW'(delta_i) * HW'(24);
      hue_ok = grey_i ? (csr.hue_low != '0) : (t17 < lo24 || t17 > hi24);

      skin_in = rgb_ok_i && crcb_ok && hue_ok;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff  <= pix_i;
         skin_ff <= skin_in;
      end
   end

   assign pix_o  = pix_ff;
   assign skin_o = skin_ff;

endmodule

// File: hw/rtl/skin_pixel_classifier.sv
//------------------------------------------------------------------------------
// skin_pixel_classifier
// An accepted req transaction reaches rsp_valid through four register stages
// (RGB rule and Cr/Cb sums, saturation and hue numerator, bound and hue
// compares, output). Throughput: one pixel per cycle unless rsp_ready stalls.
// Reset: synchronous, clears all valid bits and loads the register defaults.
//------------------------------------------------------------------------------
module skin_pixel_classifier
   import spc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIX_W-1:0]      req_red,
   input  logic [PIX_W-1:0]      req_green,
   input  logic [PIX_W-1:0]      req_blue,
   input  logic                  req_last_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_out_red,
   output logic [PIX_W-1:0]      rsp_out_green,
   output logic [PIX_W-1:0]      rsp_out_blue,
   output logic                  rsp_is_skin,
   output logic                  rsp_out_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SW = FRAC_BITS + 11;

   pipe_ctl_type         ctl;
   csr_type              csr_ff, csr_in;
   pix_type              pix_req, pix_s1, pix_s2, pix_s3;
   logic signed [SW-1:0] cr_sum_s1, cb_sum_s1;
   logic                 rgb_ok_s1, rgb_ok_s2, grey_s2, skin_s3;
   logic [1:0]           max_sel_s1;
   logic [PIX_W-1:0]     delta_s1, delta_s2, cr_s2, cb_s2;
   logic [HUE_T_W-1:0]   hue_t_s2;
   pix_type              out_ff, out_in;
   logic                 skin_ff;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RED_MIN:   csr_in.red_min   = csr_wdata;
            CSR_GREEN_MIN: csr_in.green_min = csr_wdata;
            CSR_BLUE_MIN:  csr_in.blue_min  = csr_wdata;
            CSR_HUE_LOW:   csr_in.hue_low   = csr_wdata;
            CSR_HUE_HIGH:  csr_in.hue_high  = csr_wdata;
            default:       csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.red_min   <= RST_RED_MIN;
         csr_ff.green_min <= RST_GREEN_MIN;
         csr_ff.blue_min  <= RST_BLUE_MIN;
         csr_ff.hue_low   <= RST_HUE_LOW;
         csr_ff.hue_high  <= RST_HUE_HIGH;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign pix_req.red   = req_red;
   assign pix_req.green = req_green;
   assign pix_req.blue  = req_blue;
   assign pix_req.last  = req_last_pixel;

   spc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_ready (rsp_ready),
      .in_ready  (req_ready),
      .ctl       (ctl)
   );

   spc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .load      (ctl.load[0]),
      .pix_i     (pix_req),
      .csr       (csr_ff),
      .pix_o     (pix_s1),
      .cr_sum_o  (cr_sum_s1),
      .cb_sum_o  (cb_sum_s1),
      .rgb_ok_o  (rgb_ok_s1),
      .max_sel_o (max_sel_s1),
      .delta_o   (delta_s1)
   );

   spc_convert #(.FRAC_BITS(FRAC_BITS)) u_convert (
      .clock     (clock),
      .load      (ctl.load[1]),
      .pix_i     (pix_s1),
      .cr_sum_i  (cr_sum_s1),
      .cb_sum_i  (cb_sum_s1),
      .rgb_ok_i  (rgb_ok_s1),
      .max_sel_i (max_sel_s1),
      .delta_i   (delta_s1),
      .pix_o     (pix_s2),
      .cr_o      (cr_s2),
      .cb_o      (cb_s2),
      .rgb_ok_o  (rgb_ok_s2),
      .hue_t_o   (hue_t_s2),
      .delta_o   (delta_s2),
      .grey_o    (grey_s2)
   );

   spc_decide #(.FRAC_BITS(FRAC_BITS)) u_decide (
      .clock    (clock),
      .load     (ctl.load[2]),
      .pix_i    (pix_s2),
      .cr_i     (cr_s2),
      .cb_i     (cb_s2),
      .rgb_ok_i (rgb_ok_s2),
      .hue_t_i  (hue_t_s2),
      .delta_i  (delta_s2),
      .grey_i   (grey_s2),
      .csr      (csr_ff),
      .pix_o    (pix_s3),
      .skin_o   (skin_s3)
   );

   // non-skin pixels go out black
   always_comb begin
      out_in.red   = skin_s3 ? pix_s3.red   : '0;
      out_in.green = skin_s3 ? pix_s3.green : '0;
      out_in.blue  = skin_s3 ? pix_s3.blue  : '0;
      out_in.last  = pix_s3.last;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         out_ff  <= out_in;
         skin_ff <= skin_s3;
      end
   end

   assign rsp_valid     = ctl.valid[3];
   assign rsp_out_red   = out_ff.red;
   assign rsp_out_green = out_ff.green;
   assign rsp_out_blue  = out_ff.blue;
   assign rsp_is_skin   = skin_ff;
   assign rsp_out_last  = out_ff.last;

endmodule

// File: hw/rtl/spc_checker.sv
//------------------------------------------------------------------------------
// spc_checker
// Port-level checks for the skin pixel classifier, bound to the top level.
//------------------------------------------------------------------------------
`include "skin_pixel_classifier_assert.svh"

module spc_checker
   import spc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] rsp_out_red,
   input logic [PIX_W-1:0] rsp_out_green,
   input logic [PIX_W-1:0] rsp_out_blue,
   input logic             rsp_is_skin,
   input logic             rsp_out_last
);

   localparam int RW = 3 * PIX_W + 2;

   logic          no_stall;
   logic          rsp_black;
   logic          rsp_held;
   logic [RW-1:0] rsp_word_in;
   logic [RW-1:0] rsp_word_ff;

   assign no_stall    = !rsp_valid || rsp_ready;
   assign rsp_black   = (rsp_out_red == '0) && (rsp_out_green == '0) &&
                        (rsp_out_blue == '0);
   assign rsp_word_in = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_is_skin,
                         rsp_out_last};

   // previous cycle's rsp payload
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_held = (rsp_word_in == rsp_word_ff);

   `SPC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp_valid after reset")
   `SPC_ASSERT_NOW(a_ready_when_free, clock, reset, no_stall, req_ready, "req_ready low with free output")
   `SPC_ASSERT_NOW(a_black_not_skin, clock, reset, rsp_valid && !rsp_is_skin, rsp_black, "non-skin pixel not black")
   `SPC_ASSERT_NOW(a_skin_red_dominant, clock, reset, rsp_valid && rsp_is_skin, rsp_out_red > rsp_out_blue, "skin pixel with red not above blue")
   `SPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && rsp_held, "stalled rsp transaction changed")

endmodule

bind skin_pixel_classifier spc_checker u_spc_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Skin pixel classifier testbench
// Sends RGB pixels through the classifier under several register settings,
// with random sender gaps and receiver stalls. A local fixed-point predictor
// computes the expected output for each pixel, and every returned
// transaction is checked field by field, in order.
//------------------------------------------------------------------------------
module tb_top;
   import spc_pkg::*;

   localparam int     FRAC         = FRAC_BITS_DEF;
   localparam longint ONE          = longint'(1) << FRAC;
   localparam int     PIPE_LAT     = 4;
   localparam int     LIMIT_CYCLES = 200000;

   function automatic longint q_frac(input longint millionths);
      return (millionths * ONE + 500000) / 1000000;
   endfunction

   localparam longint Q_CR_R = q_frac(500000);
   localparam longint Q_CR_G = q_frac(418688);
   localparam longint Q_CR_B = q_frac(81312);
   localparam longint Q_CB_R = q_frac(168736);
   localparam longint Q_CB_G = q_frac(331264);
   localparam longint Q_CB_B = q_frac(500000);
   localparam longint Q_S3   = q_frac(1586200);
   localparam longint Q_O3   = q_frac(20000000);
   localparam longint Q_S4   = q_frac(344800);
   localparam longint Q_O4   = q_frac(76206900);
   localparam longint Q_S5   = q_frac(4565200);
   localparam longint Q_O5   = q_frac(234565200);
   localparam longint Q_S6   = q_frac(1150000);
   localparam longint Q_O6   = q_frac(301750000);
   localparam longint Q_S7   = q_frac(2285700);
   localparam longint Q_O7   = q_frac(432850000);

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             skin;
      logic             last;
   } classified_pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_red;
   logic [PIX_W-1:0]      req_green;
   logic [PIX_W-1:0]      req_blue;
   logic                  req_last_pixel;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [PIX_W-1:0]      rsp_out_red;
   logic [PIX_W-1:0]      rsp_out_green;
   logic [PIX_W-1:0]      rsp_out_blue;
   logic                  rsp_is_skin;
   logic                  rsp_out_last;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   csr_type              thresholds;
   classified_pixel_type expected_pixels[$];
   int                   errors;
   int                   pixels_sent;
   int                   skin_seen;
   int                   reg_writes;
   int                   cycle_count;
   int                   burst_left;
   int                   stall_left;
   bit                   tx_gaps_on;
   bit                   rx_stalls_on;

   skin_pixel_classifier #(.FRAC_BITS(FRAC)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_is_skin    (rsp_is_skin),
      .rsp_out_last   (rsp_out_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout after %0d cycles, %0d transactions outstanding", $time,
                  cycle_count, expected_pixels.size());
         $display("Verification failed");
         $finish;
      end
   end

   //---------------------------------------------------------------------------
   // Predictor
   //---------------------------------------------------------------------------
   function automatic longint clamp_chroma(input longint sum);
      longint v;
      if (sum < 0) return 0;
      v = sum >>> FRAC;
      return (v > 255) ? 255 : v;
   endfunction

   function automatic logic pixel_is_skin(input logic [PIX_W-1:0] r8, g8, b8);
      longint r, g, b, mx, mn, drg, cr, cb, lhs, d, t, lo, hi;
      logic   day, flash, bounds, hue_ok;
      r   = longint'(r8);
      g   = longint'(g8);
      b   = longint'(b8);
      mx  = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      mn  = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      drg = (r > g) ? r - g : g - r;
      day = r > longint'(thresholds.red_min) && g > longint'(thresholds.green_min) &&
            b > longint'(thresholds.blue_min) && (mx - mn) > 15 && drg > 15 &&
            r > g && r > b;
      flash = r > 220 && g > 210 && b > 170 && drg <= 15 && r > b && g > b;

      cr  = clamp_chroma(128 * ONE + Q_CR_R * r - Q_CR_G * g - Q_CR_B * b + ONE / 2);
      cb  = clamp_chroma(128 * ONE - Q_CB_R * r - Q_CB_G * g + Q_CB_B * b + ONE / 2);
      lhs = cr * ONE;
      bounds = lhs <= Q_S3 * cb + Q_O3 && lhs >= Q_S4 * cb + Q_O4 &&
               lhs >= -Q_S5 * cb + Q_O5 && lhs <= -Q_S6 * cb + Q_O6 &&
               lhs <= -Q_S7 * cb + Q_O7;

      lo = longint'(thresholds.hue_low);
      hi = longint'(thresholds.hue_high);
      d  = mx - mn;
      if (d == 0) begin
         hue_ok = lo > 0;
      end else begin
         if (mx == r) t = 60 * (g - b);
         else if (mx == g) t = 120 * d + 60 * (b - r);
         else t = 240 * d + 60 * (r - g);
         if (t < 0) t += 360 * d;
         hue_ok = 17 * t < 24 * lo * d || 17 * t > 24 * hi * d;
      end
      return (day || flash) && bounds && hue_ok;
   endfunction

   function automatic classified_pixel_type classify_pixel(input logic [PIX_W-1:0] r, g, b,
                                                           input logic last);
      classified_pixel_type p;
      p.skin  = pixel_is_skin(r, g, b);
      p.red   = p.skin ? r : '0;
      p.green = p.skin ? g : '0;
      p.blue  = p.skin ? b : '0;
      p.last  = last;
      return p;
   endfunction

   //---------------------------------------------------------------------------
   // Receiver and checker
   //---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!rx_stalls_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      classified_pixel_type exp_p;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual r=%0d g=%0d b=%0d",
                     $time, rsp_out_red, rsp_out_green, rsp_out_blue);
            errors++;
         end else begin
            exp_p = expected_pixels.pop_front();
            check_field("out_red", exp_p.red, rsp_out_red);
            check_field("out_green", exp_p.green, rsp_out_green);
            check_field("out_blue", exp_p.blue, rsp_out_blue);
            check_field("is_skin", exp_p.skin, rsp_is_skin);
            check_field("out_last", exp_p.last, rsp_out_last);
            if (rsp_is_skin) skin_seen++;
         end
      end
   end

   //---------------------------------------------------------------------------
   // Sender and register access
   //---------------------------------------------------------------------------
   task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid      <= 1'b1;
      req_red        <= r;
      req_green      <= g;
      req_blue       <= b;
      req_last_pixel <= last;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(classify_pixel(r, g, b, last));
      burst_left--;
      pixels_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      reg_writes++;
      case (idx)
         CSR_RED_MIN:   thresholds.red_min   = val;
         CSR_GREEN_MIN: thresholds.green_min = val;
         CSR_BLUE_MIN:  thresholds.blue_min  = val;
         CSR_HUE_LOW:   thresholds.hue_low   = val;
         CSR_HUE_HIGH:  thresholds.hue_high  = val;
         default: ;
      endcase
   endtask

   task automatic load_thresholds(input csr_type c);
      wait_drained();
      write_reg(CSR_RED_MIN, c.red_min);
      write_reg(CSR_GREEN_MIN, c.green_min);
      write_reg(CSR_BLUE_MIN, c.blue_min);
      write_reg(CSR_HUE_LOW, c.hue_low);
      write_reg(CSR_HUE_HIGH, c.hue_high);
   endtask

   task automatic random_pixel(output logic [PIX_W-1:0] r, g, b);
      int lo, hi;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            r = PIX_W'($urandom_range(0, 255));
            g = PIX_W'($urandom_range(0, 255));
            b = PIX_W'($urandom_range(0, 255));
         end
         4, 5, 6: begin
            // daylight skin tones
            r = PIX_W'($urandom_range(96, 255));
            g = PIX_W'($urandom_range(36, int'(r) - 16));
            b = PIX_W'($urandom_range(16, int'(g)));
         end
         7: begin
            // flash-lit skin tones
            r  = PIX_W'($urandom_range(221, 255));
            lo = (int'(r) - 15 > 211) ? int'(r) - 15 : 211;
            hi = (int'(r) + 15 < 255) ? int'(r) + 15 : 255;
            g  = PIX_W'($urandom_range(lo, hi));
            hi = ((r < g) ? int'(r) : int'(g)) - 1;
            b  = PIX_W'($urandom_range(171, hi));
         end
         8: begin
            r = PIX_W'($urandom_range(0, 255));
            g = r;
            b = r;
         end
         default: begin
            // two components share the maximum
            r  = PIX_W'($urandom_range(1, 255));
            lo = int'($urandom_range(0, int'(r) - 1));
            case ($urandom_range(0, 2))
               0:       begin g = r;  b = PIX_W'(lo); end
               1:       begin g = PIX_W'(lo); b = r;  end
               default: begin b = r;  g = r; r = PIX_W'(lo); end
            endcase
         end
      endcase
   endtask

   task automatic send_random_pixels(input int count);
      logic [PIX_W-1:0] r, g, b;
      for (int i = 0; i < count; i++) begin
         random_pixel(r, g, b);
         send_pixel(r, g, b, $urandom_range(0, 15) == 0);
      end
   endtask

   //---------------------------------------------------------------------------
   // Tests
   //---------------------------------------------------------------------------
   task automatic test_directed_corners();
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);         // grey, black
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);   // grey, white
      send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
      send_pixel(8'd200, 8'd140, 8'd110, 1'b0);   // typical daylight skin
      send_pixel(8'd200, 8'd90, 8'd120, 1'b0);    // red sector, wraps negative hue
      send_pixel(8'd240, 8'd230, 8'd190, 1'b1);   // flash case
      send_pixel(8'd255, 8'd250, 8'd200, 1'b0);   // flash case
      send_pixel(8'd200, 8'd200, 8'd100, 1'b0);   // red/green tie
      send_pixel(8'd100, 8'd200, 8'd200, 1'b0);   // green/blue tie
      send_pixel(8'd200, 8'd100, 8'd200, 1'b1);   // red/blue tie
      send_pixel(8'd91, 8'd36, 8'd16, 1'b0);      // just above daylight mins
      send_pixel(8'd90, 8'd35, 8'd15, 1'b0);      // on daylight mins
      send_pixel(8'd150, 8'd134, 8'd100, 1'b0);   // r-g difference of 16
      send_pixel(8'd150, 8'd135, 8'd100, 1'b0);   // r-g difference of 15
      send_pixel(8'd221, 8'd211, 8'd171, 1'b1);   // flash lower edge
      send_pixel(8'd220, 8'd210, 8'd170, 1'b0);
      send_pixel(8'd1, 8'd254, 8'd127, 1'b1);
      wait_drained();
   endtask

   task automatic test_register_extremes();
      csr_type c;
      c = '{red_min: 8'd0, green_min: 8'd0, blue_min: 8'd0, hue_low: 8'd255, hue_high: 8'd0};
      load_thresholds(c);
      send_random_pixels(30);
      c = '{red_min: 8'd255, green_min: 8'd255, blue_min: 8'd255, hue_low: 8'd0,
            hue_high: 8'd255};
      load_thresholds(c);
      send_random_pixels(30);
      c = '{red_min: 8'd0, green_min: 8'd0, blue_min: 8'd0, hue_low: 8'd0, hue_high: 8'd255};
      load_thresholds(c);
      send_random_pixels(20);
      // writes to unused indexes must leave the thresholds alone
      wait_drained();
      for (int i = int'(CSR_HUE_HIGH) + 1; i < (1 << CSR_IDX_W); i++)
         write_reg(CSR_IDX_W'(i), CSR_DATA_W'($urandom_range(0, 255)));
      send_random_pixels(20);
      wait_drained();
   endtask

   task automatic test_random_phases();
      csr_type c;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: c = '{red_min: RST_RED_MIN, green_min: RST_GREEN_MIN, blue_min: RST_BLUE_MIN,
                     hue_low: RST_HUE_LOW, hue_high: RST_HUE_HIGH};
            4: begin
               c.red_min   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               c.green_min = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               c.blue_min  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               c.hue_low   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               c.hue_high  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: begin
               c.red_min   = PIX_W'($urandom_range(0, 140));
               c.green_min = PIX_W'($urandom_range(0, 80));
               c.blue_min  = PIX_W'($urandom_range(0, 60));
               c.hue_low   = PIX_W'($urandom_range(0, 60));
               c.hue_high  = PIX_W'($urandom_range(160, 255));
            end
         endcase
         load_thresholds(c);
         tx_gaps_on   = (ph != 1) && $urandom_range(0, 3) != 0;
         rx_stalls_on = (ph != 1) && $urandom_range(0, 3) != 0;
         send_random_pixels(80);
      end
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      wait_drained();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_red        = '0;
      req_green      = '0;
      req_blue       = '0;
      req_last_pixel = 1'b0;
      rsp_ready      = 1'b0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      errors         = 0;
      pixels_sent    = 0;
      skin_seen      = 0;
      reg_writes     = 0;
      cycle_count    = 0;
      burst_left     = 0;
      stall_left     = 0;
      tx_gaps_on     = 1'b1;
      rx_stalls_on   = 1'b1;
      thresholds     = '{red_min: RST_RED_MIN, green_min: RST_GREEN_MIN,
                         blue_min: RST_BLUE_MIN, hue_low: RST_HUE_LOW,
                         hue_high: RST_HUE_HIGH};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_register_extremes();
      test_random_phases();

      wait_drained();
      if (expected_pixels.size() != 0) begin
         $display("%0t: %0d transactions never returned", $time, expected_pixels.size());
         errors++;
      end
      $display("Summary: %0d pixels classified, %0d marked skin, %0d register writes,",
               pixels_sent, skin_seen, reg_writes);
      $display("         %0d cycles with random sender gaps and receiver stalls",
               cycle_count);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", errors);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: skin_pixel_classifier.f
+incdir+hw/rtl
hw/rtl/spc_pkg.sv
hw/rtl/spc_pipe_ctrl.sv
hw/rtl/spc_front.sv
hw/rtl/spc_convert.sv
hw/rtl/spc_decide.sv
hw/rtl/skin_pixel_classifier.sv
hw/rtl/spc_checker.sv
bench/tb_top.sv
